// ===== hw/rtl/tpw_pkg.sv =====
// ----------------------------------------------------------------------------
// tpw_pkg: shared types and constants of the affine bilinear warp
// Holds the register map codes, the beat carried down the pipeline and the
// geometry of the pipelined divider.
// ----------------------------------------------------------------------------
package tpw_pkg;

   // Register map, one word per register.
   typedef enum logic [2:0] {
      REG_OUT_WIDTH  = 3'd0,
      REG_OUT_HEIGHT = 3'd1,
      REG_ORIGIN_X   = 3'd2,
      REG_ORIGIN_Y   = 3'd3,
      REG_ROW_END_X  = 3'd4,
      REG_ROW_END_Y  = 3'd5,
      REG_COL_END_X  = 3'd6,
      REG_COL_END_Y  = 3'd7
   } reg_index_type;

   // Request kinds.
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // One request beat as it travels through the pipeline.
   typedef struct packed {
      logic       kind;
      logic [6:0] load_x;
      logic [6:0] load_y;
      logic [7:0] load_red;
      logic [7:0] load_green;
      logic [7:0] load_blue;
      logic [7:0] load_alpha;
      logic [7:0] out_x;
      logic [7:0] out_y;
   } item_type;

   // Divider geometry: 32 dividend bits, four quotient bits per stage.
   localparam int DIV_BITS     = 32;
   localparam int DIV_STEPS    = 4;
   localparam int DIV_STAGES   = DIV_BITS / DIV_STEPS;
   localparam int DIVISOR_BITS = 9;
   localparam int REM_BITS     = DIVISOR_BITS + 1;

   // One divider stage: dividend bits shift out on top, quotient bits in below.
   typedef struct packed {
      logic [DIV_BITS-1:0] qd;
      logic [REM_BITS-1:0] rem;
      logic                neg;
   } div_stage_type;

   // Cycles from the accepting edge to the edge that takes the result.
   localparam int LATENCY = DIV_STAGES + 9;

endpackage

// ===== hw/rtl/tpw_div.sv =====
// ----------------------------------------------------------------------------
// tpw_div: pipelined unsigned divider
// Restoring long division, four quotient bits per register stage, one new
// dividend accepted every cycle. A sign flag travels alongside the data.
// ----------------------------------------------------------------------------
module tpw_div (
   input  logic                                clock,
   input  logic [tpw_pkg::DIV_BITS-1:0]        numer,
   input  logic [tpw_pkg::DIVISOR_BITS-1:0]    divisor,
   input  logic                                neg_in,
   output logic [tpw_pkg::DIV_BITS-1:0]        quotient,
   output logic                                rem_nonzero,
   output logic                                neg_out
);
   import tpw_pkg::*;

   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];

   // Four restoring steps on one stage's state.
   function automatic div_stage_type div_steps(div_stage_type s,
                                               logic [DIVISOR_BITS-1:0] d);
      div_stage_type       r;
      logic [REM_BITS-1:0] trial;
      r = s;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial = {r.rem[REM_BITS-2:0], r.qd[DIV_BITS-1]};
         if (trial >= {1'b0, d}) begin
            r.rem = trial - {1'b0, d};
            r.qd  = {r.qd[DIV_BITS-2:0], 1'b1};
         end else begin
            r.rem = trial;
            r.qd  = {r.qd[DIV_BITS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // The first stage starts from a zero remainder.
   assign stage_in[0] = div_steps(div_stage_type'({numer, {REM_BITS{1'b0}}, neg_in}),
                                  divisor);

   for (genvar g = 1; g < DIV_STAGES; g++) begin : g_stage
      assign stage_in[g] = div_steps(stage_ff[g-1], divisor);
   end

   // Stage registers carry payload only.
   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   assign quotient    = stage_ff[DIV_STAGES-1].qd;
   assign rem_nonzero = |stage_ff[DIV_STAGES-1].rem;
   assign neg_out     = stage_ff[DIV_STAGES-1].neg;

endmodule

// ===== hw/rtl/three_point_affine_bilinear_warp.sv =====
// ----------------------------------------------------------------------------
// three_point_affine_bilinear_warp: affine warp with bilinear RGBA sampling
// Maps output pixels through three corner points onto a stored source image
// and blends the four neighbors of the mapped point.
// ----------------------------------------------------------------------------
// Usage. A request beat is taken at a rising edge with start high and busy
// low; busy stays low, so a beat may enter every cycle. A load beat
// (req_kind low) writes one RGBA pixel into the source image and gives no
// result. A sample beat (req_kind high) names an output pixel; its result
// shows on the rsp_ ports for one cycle with rsp_strobe high, and the edge
// that ends that cycle takes it. The receiver cannot hold results off.
// Throughput is one beat per clock. A beat passes through the capture
// register, the multiply, the pipelined dividers (four quotient bits per
// stage), mapping, clamp, the source image read and the blend, each of them
// registered. The source image sits in four banks split by row and column
// parity, so the four neighbors are read in the same cycle. Loads write the
// banks at the same pipeline stage where samples read them, which keeps
// request order. Reset clears the pipeline valid bits and sets the registers
// to their defaults; the image content is undefined until loaded. The user
// must write the registers over the APB port only while no beat is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module three_point_affine_bilinear_warp #(
   parameter int SRC_WIDTH      = 128,
   parameter int SRC_HEIGHT     = 128,
   parameter int MAX_OUT_WIDTH  = 256,
   parameter int MAX_OUT_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [6:0]  req_load_x,
   input  logic [6:0]  req_load_y,
   input  logic [7:0]  req_load_red,
   input  logic [7:0]  req_load_green,
   input  logic [7:0]  req_load_blue,
   input  logic [7:0]  req_load_alpha,
   input  logic [7:0]  req_out_x,
   input  logic [7:0]  req_out_y,
   // result channel
   output logic        rsp_strobe,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_alpha_out,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tpw_pkg::*;

   localparam int XW  = (SRC_WIDTH  > 1) ? $clog2(SRC_WIDTH)  : 1;
   localparam int YW  = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
   localparam int WB  = (SRC_WIDTH  + 1) / 2;
   localparam int HB  = (SRC_HEIGHT + 1) / 2;
   localparam int BD  = WB * HB;
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [8:0]         out_width_ff, out_height_ff;
   logic signed [12:0] origin_x_ff, origin_y_ff;
   logic signed [12:0] row_end_x_ff, row_end_y_ff;
   logic signed [12:0] col_end_x_ff, col_end_y_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= 9'd128;
         out_height_ff <= 9'd128;
         origin_x_ff   <= 13'sd0;
         origin_y_ff   <= 13'sd0;
         row_end_x_ff  <= 13'sd128;
         row_end_y_ff  <= 13'sd0;
         col_end_x_ff  <= 13'sd0;
         col_end_y_ff  <= 13'sd128;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OUT_WIDTH:  out_width_ff  <= pwdata[8:0];
            REG_OUT_HEIGHT: out_height_ff <= pwdata[8:0];
            REG_ORIGIN_X:   origin_x_ff   <= pwdata[12:0];
            REG_ORIGIN_Y:   origin_y_ff   <= pwdata[12:0];
            REG_ROW_END_X:  row_end_x_ff  <= pwdata[12:0];
            REG_ROW_END_Y:  row_end_y_ff  <= pwdata[12:0];
            REG_COL_END_X:  col_end_x_ff  <= pwdata[12:0];
            REG_COL_END_Y:  col_end_y_ff  <= pwdata[12:0];
            default:        ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         REG_OUT_WIDTH:  prdata = {23'd0, out_width_ff};
         REG_OUT_HEIGHT: prdata = {23'd0, out_height_ff};
         REG_ORIGIN_X:   prdata = {19'd0, origin_x_ff};
         REG_ORIGIN_Y:   prdata = {19'd0, origin_y_ff};
         REG_ROW_END_X:  prdata = {19'd0, row_end_x_ff};
         REG_ROW_END_Y:  prdata = {19'd0, row_end_y_ff};
         REG_COL_END_X:  prdata = {19'd0, col_end_x_ff};
         REG_COL_END_Y:  prdata = {19'd0, col_end_y_ff};
         default:        prdata = '0;
      endcase
   end

   // Divisors saturated to their legal range; the user must let the registers
   // hold still while beats are in flight; the block does not enforce this.
   function automatic logic [8:0] sat_div(logic [8:0] v, int hi);
      if (v == 9'd0) begin
         return 9'd1;
      end else if (32'(v) > hi) begin
         return 9'(hi);
      end
      return v;
   endfunction

   logic [8:0]         div_w, div_h;
   logic signed [13:0] dir_diff [4];

   assign div_w = sat_div(out_width_ff, MAX_OUT_WIDTH);
   assign div_h = sat_div(out_height_ff, MAX_OUT_HEIGHT);

   // Direction vectors: u by x, u by y, v by x, v by y.
   assign dir_diff[0] = 14'(row_end_x_ff) - 14'(origin_x_ff);
   assign dir_diff[1] = 14'(col_end_x_ff) - 14'(origin_x_ff);
   assign dir_diff[2] = 14'(row_end_y_ff) - 14'(origin_y_ff);
   assign dir_diff[3] = 14'(col_end_y_ff) - 14'(origin_y_ff);

   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // Stage 1: capture the request beat
   // ------------------------------------------------------------------
   logic     v1_ff;
   item_type it1_ff, it1_in;

   always_comb begin
      it1_in.kind       = req_kind;
      it1_in.load_x     = req_load_x;
      it1_in.load_y     = req_load_y;
      it1_in.load_red   = req_load_red;
      it1_in.load_green = req_load_green;
      it1_in.load_blue  = req_load_blue;
      it1_in.load_alpha = req_load_alpha;
      it1_in.out_x      = req_out_x;
      it1_in.out_y      = req_out_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      it1_ff <= it1_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: direction times output position, split into sign and size
   // ------------------------------------------------------------------
   logic        v2_ff;
   item_type    it2_ff;
   logic        neg2_ff [4];
   logic        neg2_in [4];
   logic [20:0] mag2_ff [4];
   logic [20:0] mag2_in [4];

   always_comb begin
      logic signed [22:0] prod;
      logic signed [22:0] pos;
      logic signed [22:0] prod_neg;
      for (int i = 0; i < 4; i++) begin
         pos = ((i % 2) == 0) ? 23'($signed({1'b0, it1_ff.out_x}))
                              : 23'($signed({1'b0, it1_ff.out_y}));
         prod       = 23'(dir_diff[i]) * pos;
         prod_neg   = -prod;
         neg2_in[i] = prod[22];
         mag2_in[i] = prod[22] ? prod_neg[20:0] : prod[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      it2_ff <= it1_ff;
      for (int i = 0; i < 4; i++) begin
         neg2_ff[i] <= neg2_in[i];
         mag2_ff[i] <= mag2_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Dividers: size times 256 over the output width or height
   // ------------------------------------------------------------------
   logic [DIV_BITS-1:0] quo [4];
   logic                rem_nz [4];
   logic                quo_neg [4];

   for (genvar g = 0; g < 4; g++) begin : g_div
      tpw_div u_div (
         .clock       (clock),
         .numer       ({3'd0, mag2_ff[g], 8'd0}),
         .divisor     (((g % 2) == 0) ? div_w : div_h),
         .neg_in      (neg2_ff[g]),
         .quotient    (quo[g]),
         .rem_nonzero (rem_nz[g]),
         .neg_out     (quo_neg[g])
      );
   end

   // The beat waits in a delay line matched to the divider depth.
   logic     vd_ff [DIV_STAGES];
   item_type itd_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v2_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
      itd_ff[0] <= it2_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         itd_ff[i] <= itd_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: floor of the signed quotients
   // ------------------------------------------------------------------
   logic               v3_ff;
   item_type           it3_ff;
   logic signed [31:0] t3_ff [4];
   logic signed [31:0] t3_in [4];

   always_comb begin
      logic [31:0] up;
      for (int i = 0; i < 4; i++) begin
         up       = quo[i] + {31'd0, rem_nz[i]};
         t3_in[i] = quo_neg[i] ? -$signed(up) : $signed(quo[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= vd_ff[DIV_STAGES-1];
      end
      it3_ff <= itd_ff[DIV_STAGES-1];
      for (int i = 0; i < 4; i++) begin
         t3_ff[i] <= t3_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: source point, with 8 fraction bits, in signed fixed point
   // ------------------------------------------------------------------
   logic               v4_ff;
   item_type           it4_ff;
   logic signed [31:0] u4_ff, w4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      it4_ff <= it3_ff;
      u4_ff  <= $signed({{11{origin_x_ff[12]}}, origin_x_ff, 8'd0}) + t3_ff[0] + t3_ff[1];
      w4_ff  <= $signed({{11{origin_y_ff[12]}}, origin_y_ff, 8'd0}) + t3_ff[2] + t3_ff[3];
   end

   // ------------------------------------------------------------------
   // Stage 5: clamp the neighbors and form the bank addresses
   // ------------------------------------------------------------------
   function automatic logic [XW-1:0] clamp_x(logic signed [23:0] i);
      if (i < 24'sd0) begin
         return '0;
      end else if (i > $signed(24'(SRC_WIDTH - 1))) begin
         return XW'(SRC_WIDTH - 1);
      end
      return i[XW-1:0];
   endfunction

   function automatic logic [YW-1:0] clamp_y(logic signed [23:0] i);
      if (i < 24'sd0) begin
         return '0;
      end else if (i > $signed(24'(SRC_HEIGHT - 1))) begin
         return YW'(SRC_HEIGHT - 1);
      end
      return i[YW-1:0];
   endfunction

   function automatic logic [BAW-1:0] bank_addr(logic [31:0] x, logic [31:0] y);
      return BAW'((y >> 1) * WB + (x >> 1));
   endfunction

   logic           v5_ff;
   item_type       it5_ff;
   logic [7:0]     fu5_ff, fv5_ff;
   logic [3:0]     par5_ff, par5_in;
   logic [BAW-1:0] raddr5_ff [4];
   logic [BAW-1:0] raddr5_in [4];

   always_comb begin
      logic signed [23:0] iu, iv;
      logic [XW-1:0]      xa, xb, rx;
      logic [YW-1:0]      ya, yb, ry;
      iu = u4_ff[31:8];
      iv = w4_ff[31:8];
      xa = clamp_x(iu);
      xb = clamp_x(iu + 24'sd1);
      ya = clamp_y(iv);
      yb = clamp_y(iv + 24'sd1);
      // Parity bits: x of a, x of b, y of a, y of b.
      par5_in = {yb[0], ya[0], xb[0], xa[0]};
      // Bank b holds column parity b[0] and row parity b[1].
      for (int b = 0; b < 4; b++) begin
         rx = (xa[0] == b[0]) ? xa : xb;
         ry = (ya[0] == b[1]) ? ya : yb;
         raddr5_in[b] = bank_addr(32'(rx), 32'(ry));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      it5_ff  <= it4_ff;
      fu5_ff  <= u4_ff[7:0];
      fv5_ff  <= w4_ff[7:0];
      par5_ff <= par5_in;
      for (int b = 0; b < 4; b++) begin
         raddr5_ff[b] <= raddr5_in[b];
      end
   end

   // ------------------------------------------------------------------
   // Source image banks: loads write and samples read at this stage
   // ------------------------------------------------------------------
   logic           load_hit;
   logic [1:0]     wbank;
   logic [BAW-1:0] waddr;
   logic [31:0]    wdata;
   logic [31:0]    rdata_ff [4];

   assign load_hit = v5_ff && (it5_ff.kind == KIND_LOAD)
                     && (32'(it5_ff.load_x) < SRC_WIDTH)
                     && (32'(it5_ff.load_y) < SRC_HEIGHT);
   assign wbank = {it5_ff.load_y[0], it5_ff.load_x[0]};
   assign waddr = bank_addr(32'(it5_ff.load_x), 32'(it5_ff.load_y));
   assign wdata = {it5_ff.load_alpha, it5_ff.load_blue, it5_ff.load_green,
                   it5_ff.load_red};

   for (genvar gb = 0; gb < 4; gb++) begin : g_bank
      logic [31:0] mem_ff [BD];

      always_ff @(posedge clock) begin
         if (load_hit && (wbank == 2'(gb))) begin
            mem_ff[waddr] <= wdata;
         end
         rdata_ff[gb] <= mem_ff[raddr5_ff[gb]];
      end
   end

   logic       v6_ff, kind6_ff;
   logic [7:0] ox6_ff, oy6_ff, fu6_ff, fv6_ff;
   logic [3:0] par6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      kind6_ff <= it5_ff.kind;
      ox6_ff   <= it5_ff.out_x;
      oy6_ff   <= it5_ff.out_y;
      fu6_ff   <= fu5_ff;
      fv6_ff   <= fv5_ff;
      par6_ff  <= par5_ff;
   end

   // ------------------------------------------------------------------
   // Stage 7: route the neighbors and form the blend weights
   // ------------------------------------------------------------------
   logic        v7_ff, kind7_ff;
   logic [7:0]  ox7_ff, oy7_ff;
   logic [31:0] p7_ff [4];
   logic [16:0] wt7_ff [4];
   logic [16:0] wt7_in [4];

   always_comb begin : s7_weights
      logic [8:0] a, b;
      a = 9'd256 - {1'b0, fu6_ff};
      b = 9'd256 - {1'b0, fv6_ff};
      wt7_in[0] = 17'(a) * 17'(b);
      wt7_in[1] = 17'({1'b0, fu6_ff}) * 17'(b);
      wt7_in[2] = 17'(a) * 17'({1'b0, fv6_ff});
      wt7_in[3] = 17'({1'b0, fu6_ff}) * 17'({1'b0, fv6_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      kind7_ff <= kind6_ff;
      ox7_ff   <= ox6_ff;
      oy7_ff   <= oy6_ff;
      p7_ff[0] <= rdata_ff[{par6_ff[2], par6_ff[0]}];
      p7_ff[1] <= rdata_ff[{par6_ff[2], par6_ff[1]}];
      p7_ff[2] <= rdata_ff[{par6_ff[3], par6_ff[0]}];
      p7_ff[3] <= rdata_ff[{par6_ff[3], par6_ff[1]}];
      for (int i = 0; i < 4; i++) begin
         wt7_ff[i] <= wt7_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: weighted channel samples
   // ------------------------------------------------------------------
   logic        v8_ff, kind8_ff;
   logic [7:0]  ox8_ff, oy8_ff;
   logic [24:0] prod8_ff [4][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
      kind8_ff <= kind7_ff;
      ox8_ff   <= ox7_ff;
      oy8_ff   <= oy7_ff;
      for (int c = 0; c < 4; c++) begin
         for (int n = 0; n < 4; n++) begin
            prod8_ff[c][n] <= 25'(wt7_ff[n]) * 25'(p7_ff[n][8*c +: 8]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 9: sum, truncate and present the result
   // ------------------------------------------------------------------
   logic       strobe9_ff;
   logic [7:0] ox9_ff, oy9_ff;
   logic [7:0] chan9_ff [4];
   logic [7:0] chan9_in [4];

   always_comb begin
      logic [24:0] sum;
      for (int c = 0; c < 4; c++) begin
         sum = prod8_ff[c][0] + prod8_ff[c][1] + prod8_ff[c][2] + prod8_ff[c][3];
         chan9_in[c] = sum[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe9_ff <= 1'b0;
      end else begin
         strobe9_ff <= v8_ff && (kind8_ff == KIND_SAMPLE);
      end
      ox9_ff <= ox8_ff;
      oy9_ff <= oy8_ff;
      for (int c = 0; c < 4; c++) begin
         chan9_ff[c] <= chan9_in[c];
      end
   end

   assign rsp_strobe    = strobe9_ff;
   assign rsp_pixel_x   = ox9_ff;
   assign rsp_pixel_y   = oy9_ff;
   assign rsp_red_out   = chan9_ff[0];
   assign rsp_green_out = chan9_ff[1];
   assign rsp_blue_out  = chan9_ff[2];
   assign rsp_alpha_out = chan9_ff[3];

endmodule

// ===== hw/rtl/tpw_checker.sv =====
// ----------------------------------------------------------------------------
// tpw_checker: port-level checks of the affine bilinear warp
// Ties every result strobe to a sample beat a fixed latency earlier and
// checks that the output position travels with it.
// ----------------------------------------------------------------------------
module tpw_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_kind,
   input logic [7:0] req_out_x,
   input logic [7:0] req_out_y,
   input logic       rsp_strobe,
   input logic [7:0] rsp_pixel_x,
   input logic [7:0] rsp_pixel_y,
   input logic       pready
);
   import tpw_pkg::*;

   // A sample beat always yields one result after the fixed latency.
   a_sample_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind) |-> ##LATENCY rsp_strobe)
      else $error("sample beat gave no result");

   // A load beat leaves its result slot empty.
   a_load_gives_none: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_kind) |-> ##LATENCY !rsp_strobe)
      else $error("load beat gave a result");

   // Every result traces back to a sample beat.
   a_result_has_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_kind, LATENCY))
      else $error("result without a sample beat");

   // The output position echoes the request.
   a_position_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pixel_x == $past(req_out_x, LATENCY))
                  && (rsp_pixel_y == $past(req_out_y, LATENCY)))
      else $error("result position does not match its request");

   // The register port never waits.
   a_pready_high: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind three_point_affine_bilinear_warp tpw_checker u_tpw_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_kind    (req_kind),
   .req_out_x   (req_out_x),
   .req_out_y   (req_out_y),
   .rsp_strobe  (rsp_strobe),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .pready      (pready)
);
